// ===== rtl/otc_pkg.sv =====
// ---------------------------------------------------------------------------
// otc_pkg
// Shared types and constants for the orbit trajectory classifier.
// ---------------------------------------------------------------------------
package otc_pkg;

    // Guard bits applied to positions before the CORDIC pass
    localparam int GuardShift = 8;
    // CORDIC gain correction, Q0.32
    localparam logic [31:0] GainQ32 = 32'd2608131496;
    // Width of the CORDIC x/y datapath
    localparam int CordW = 42;

    // Trajectory class codes
    typedef enum logic [2:0] {
        CLS_UNCLEAR = 3'd0,
        CLS_PLUNGE  = 3'd1,
        CLS_ESCAPE  = 3'd2,
        CLS_CIRCLE  = 3'd3,
        CLS_BOUNDED = 3'd4
    } t_class;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture a new position, start a vector pass
        logic step;      // run one CORDIC rotation
        logic gain_lo;   // multiply low half of magnitude
        logic gain_hi;   // multiply high half, form radius
        logic update;    // fold radius and angle into the run state
        logic finish;    // form the result word and clear the run state
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_step; // current rotation is the final one
    } t_stat;

    // atan(2^-i) in Q0.32 turns
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_turns = v;
        end
    endfunction

endpackage

// ===== rtl/orbit_trajectory_classifier.sv =====
// ---------------------------------------------------------------------------
// orbit_trajectory_classifier
// Classifies one body's run of positions by radius range and angle sweep.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one position word per sample: pos_x, pos_y,
//   with tlast marking the last sample of a run. Master channel m_axis
//   carries one result word per run, issued after the last sample.
//   Each sample is accepted, then runs CORDIC_STEPS rotations of the shared
//   vectoring unit, the split gain multiply and an update of the run state.
//   A last sample then waits while the receiver stalls a held word in the
//   output register, and then builds the result word.
//   Result word then waits in the output register; the next sample can be
//   taken, but a further result waits until the receiver takes the first.
//   Synchronous reset clears the run state and drops any pending result.
// ---------------------------------------------------------------------------
module orbit_trajectory_classifier #(
    parameter int ANGLE_BITS   = 16,
    parameter int SWEEP_BITS   = 48,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // pos_x [31:0], pos_y [63:32]
    input  logic         s_axis_tlast,  // last_sample
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind [2:0], radius_first [34:3], radius_last [66:35],
    // radius_least [98:67], radius_greatest [130:99], drift [163:131],
    // revolutions [211:164], stays_bounded [212], zero [215:213]
    output logic [215:0] m_axis_tdata
);

    otc_pkg::t_cmd  w_cmd;
    otc_pkg::t_stat w_stat;
    logic w_fire, w_out_load, w_ready;

    logic [2:0]         w_class;
    logic [31:0]        w_rf, w_rl, w_rmin, w_rmax;
    logic signed [32:0] w_drift;
    logic signed [47:0] w_revs;
    logic               w_bnd;

    logic         r_valid;
    logic [215:0] r_data;

    assign w_fire        = s_axis_tvalid && w_ready;
    assign s_axis_tready = w_ready;

    otc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_fire),
        .i_in_last  (s_axis_tlast),
        .i_out_busy (r_valid && !m_axis_tready),
        .i_stat     (w_stat),
        .o_in_ready (w_ready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    otc_datapath #(
        .ANGLE_BITS   (ANGLE_BITS),
        .SWEEP_BITS   (SWEEP_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_pos_x      (s_axis_tdata[31:0]),
        .i_pos_y      (s_axis_tdata[63:32]),
        .o_stat       (w_stat),
        .o_class      (w_class),
        .o_r_first    (w_rf),
        .o_r_last     (w_rl),
        .o_r_least    (w_rmin),
        .o_r_greatest (w_rmax),
        .o_drift      (w_drift),
        .o_revs       (w_revs),
        .o_bounded    (w_bnd)
    );

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_out_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_data <= {3'b000, w_bnd, w_revs, w_drift, w_rmax, w_rmin, w_rl, w_rf, w_class};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !r_valid || m_axis_tready) else $error("result overwritten");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[215:213] == 3'b000) else $error("pad not zero");
`endif

endmodule

// ===== rtl/otc_ctrl.sv =====
// ---------------------------------------------------------------------------
// otc_ctrl
// Sequencer: load, CORDIC steps, gain multiply, state update, result.
// ---------------------------------------------------------------------------
module otc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_in_last,
    input  logic          i_out_busy,
    input  otc_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_load,
    output otc_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_STEP   = 7'b0000010,
        S_GAINLO = 7'b0000100,
        S_GAINHI = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_WAIT   = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    n_state = S_STEP;
                    n_last  = i_in_last;
                end
            end
            S_STEP:   if (i_stat.last_step) n_state = S_GAINLO;
            S_GAINLO: n_state = S_GAINHI;
            S_GAINHI: n_state = S_UPDATE;
            S_UPDATE: n_state = r_last ? S_WAIT : S_IDLE;
            S_WAIT:   if (!i_out_busy) n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_load     = (r_state == S_FINISH);
    assign o_cmd.load     = i_in_fire;
    assign o_cmd.step     = (r_state == S_STEP);
    assign o_cmd.gain_lo  = (r_state == S_GAINLO);
    assign o_cmd.gain_hi  = (r_state == S_GAINHI);
    assign o_cmd.update   = (r_state == S_UPDATE);
    assign o_cmd.finish   = (r_state == S_FINISH);

`ifndef ASSERT_OFF
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_fire_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |-> r_state == S_IDLE) else $error("accept outside idle");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH |-> !i_out_busy) else $error("finish over full output");
`endif

endmodule

// ===== rtl/otc_datapath.sv =====
// ---------------------------------------------------------------------------
// otc_datapath
// Shared CORDIC vectoring unit, gain multiply, run state and classifier.
// ---------------------------------------------------------------------------
module otc_datapath #(
    parameter int ANGLE_BITS   = 16,
    parameter int SWEEP_BITS   = 48,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  otc_pkg::t_cmd       i_cmd,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    output otc_pkg::t_stat      o_stat,
    output logic [2:0]          o_class,
    output logic [31:0]         o_r_first,
    output logic [31:0]         o_r_last,
    output logic [31:0]         o_r_least,
    output logic [31:0]         o_r_greatest,
    output logic signed [32:0]  o_drift,
    output logic signed [47:0]  o_revs,
    output logic                o_bounded
);

    localparam int W  = otc_pkg::CordW;
    localparam int SW = $clog2(CORDIC_STEPS);

    logic signed [W-1:0] r_x, r_y;
    logic [31:0]         r_z;
    logic [SW-1:0]       r_i;
    logic                r_zero;
    logic [63:0]         r_prod;
    logic [31:0]         r_rad;

    logic                r_have;
    logic [31:0]         r_first, r_least, r_great;
    logic [ANGLE_BITS-1:0] r_prev;
    logic [SWEEP_BITS-1:0] r_sweep;

    // Load with optional half-turn pre-rotation
    logic signed [W-1:0] w_lx, w_ly;
    always_comb begin
        w_lx = W'(i_pos_x) <<< otc_pkg::GuardShift;
        w_ly = W'(i_pos_y) <<< otc_pkg::GuardShift;
    end

    logic signed [W-1:0] w_dx, w_dy;
    logic [4:0]          w_si;
    assign w_si = 5'(r_i);
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign o_stat.last_step = (r_i == SW'(CORDIC_STEPS - 1));

    // Magnitude and gain product
    logic [W-1:0]  w_mag;
    logic [W-33:0] w_hi;
    logic [42:0]   w_rsum;
    logic [34:0]   w_rsh;
    assign w_mag  = (r_x > 0) ? r_x : '0;
    assign w_hi   = w_mag[W-1:32];
    assign w_rsum = 43'(w_hi) * 43'(otc_pkg::GainQ32) + 43'(r_prod[63:32]) + 43'd128;
    assign w_rsh  = w_rsum[42:8];

    // CORDIC iterations and gain multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (i_pos_x == 0) && (i_pos_y == 0);
            r_i    <= '0;
            if (i_pos_x < 0) begin
                r_x <= -w_lx;
                r_y <= -w_ly;
                r_z <= 32'h80000000;
            end else begin
                r_x <= w_lx;
                r_y <= w_ly;
                r_z <= '0;
            end
        end else if (i_cmd.step) begin
            r_i <= r_i + 1'b1;
            if (!r_y[W-1]) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + otc_pkg::atan_turns(w_si);
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - otc_pkg::atan_turns(w_si);
            end
        end
        if (i_cmd.gain_lo) r_prod <= 64'(w_mag[31:0]) * 64'(otc_pkg::GainQ32);
        if (i_cmd.gain_hi) begin
            if (r_zero)            r_rad <= '0;
            else if (|w_rsh[34:32]) r_rad <= '1;
            else                   r_rad <= w_rsh[31:0];
        end
    end

    // Angle rounded to ANGLE_BITS
    logic [31:0]           w_zr;
    logic [ANGLE_BITS-1:0] w_ang, w_d;
    assign w_zr  = r_zero ? 32'd0 : r_z + (32'd1 << (31 - ANGLE_BITS));
    assign w_ang = w_zr[31 -: ANGLE_BITS];
    assign w_d   = w_ang - r_prev;

    // Fold into run state; clear on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_have  <= 1'b0;
            r_first <= '0;
            r_least <= '0;
            r_great <= '0;
            r_prev  <= '0;
            r_sweep <= '0;
        end else if (i_cmd.update) begin
            r_have <= 1'b1;
            r_prev <= w_ang;
            if (!r_have) begin
                r_first <= r_rad;
                r_least <= r_rad;
                r_great <= r_rad;
                r_sweep <= '0;
            end else begin
                if (r_rad < r_least) r_least <= r_rad;
                if (r_rad > r_great) r_great <= r_rad;
                r_sweep <= r_sweep + SWEEP_BITS'(signed'(w_d));
            end
        end
    end

    // Keep last radius for the result
    logic [31:0] r_lastr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) r_lastr <= r_rad;
    end

    // Revolutions: scale sweep to 16 fractional bits
    localparam int XW = SWEEP_BITS + 64;
    logic signed [XW-1:0] w_sx, w_sc;
    assign w_sx = XW'(signed'(r_sweep));
    generate
        if (ANGLE_BITS > 16) begin : g_shr
            assign w_sc = w_sx >>> (ANGLE_BITS - 16);
        end else begin : g_shl
            assign w_sc = w_sx <<< (16 - ANGLE_BITS);
        end
    endgenerate

    // Classifier
    logic [34:0] w_f1, w_f2, w_f3, w_f5, w_l4, w_l5, w_g2, w_r2, w_span;
    assign w_f1   = 35'(r_first);
    assign w_f3   = 35'(r_first) * 35'd3;
    assign w_f5   = 35'(r_first) * 35'd5;
    assign w_f2   = 35'(r_first);
    assign w_l4   = 35'(r_least) << 2;
    assign w_l5   = 35'(r_least) * 35'd5;
    assign w_g2   = 35'(r_great) << 1;
    assign w_r2   = 35'(r_lastr) << 1;
    assign w_span = 35'(r_great - r_least) << 2;

    logic w_bnd;
    assign w_bnd = (w_l5 >= w_f1) && (35'(r_great) <= w_f3);

    always_comb begin
        priority if (w_l4 < w_f1 && w_r2 < w_f2)  o_class = otc_pkg::CLS_PLUNGE;
        else if (w_g2 > w_f5 && w_r2 > w_f3)      o_class = otc_pkg::CLS_ESCAPE;
        else if (w_bnd)
            o_class = (r_first != 0 && w_span <= w_f1) ? otc_pkg::CLS_CIRCLE
                                                         : otc_pkg::CLS_BOUNDED;
        else                                      o_class = otc_pkg::CLS_UNCLEAR;
    end

    assign o_r_first    = r_first;
    assign o_r_last     = r_lastr;
    assign o_r_least    = r_least;
    assign o_r_greatest = r_great;
    assign o_drift      = signed'({1'b0, r_lastr}) - signed'({1'b0, r_first});
    assign o_revs       = w_sc[47:0];
    assign o_bounded    = w_bnd;

`ifndef ASSERT_OFF
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> r_least <= r_great) else $error("least above greatest");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> !r_have && r_sweep == '0) else $error("run not cleared");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> r_sweep == '0) else $error("sweep without first");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Streams runs of body positions into the orbit trajectory classifier and
// checks each run summary word against an in-bench CORDIC and run tracker.
// Covers the edge cases, orbit-shaped runs, raw noise and flow-control stress.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CycleLimit = 600000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
    } t_sample;

    typedef struct {
        otc_pkg::t_class cls;
        logic [31:0] r_first;
        logic [31:0] r_last;
        logic [31:0] r_least;
        logic [31:0] r_great;
        logic [32:0] drift;
        logic [47:0] revs;
        logic        bounded;
    } t_summary;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;  // pos_x [31:0], pos_y [63:32]
    logic         s_axis_tlast;  // last_sample
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // kind [2:0], radius_first [34:3], radius_last [66:35],
    // radius_least [98:67], radius_greatest [130:99], drift [163:131],
    // revolutions [211:164], stays_bounded [212], zero [215:213]
    logic [215:0] m_axis_tdata;

    t_sample  pending_samples[$];
    t_summary expected_summaries[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    int  hold_left;
    int  mismatches;
    int  cycles;
    bit  s_axis_tready_seen;

    // run tracker state
    bit          run_started;
    logic [31:0] run_first;
    logic [31:0] run_least;
    logic [31:0] run_great;
    logic [15:0] run_prev_angle;
    logic [47:0] run_sweep;

    orbit_trajectory_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Vectoring pass: radius in Q16.16 and angle in 16-bit binary turns
    task automatic polar_of(input logic [31:0] px, input logic [31:0] py,
                            output logic [31:0] radius, output logic [15:0] angle);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] r;
        logic [31:0] zr;
        x = longint'($signed(px)) * 256;
        y = longint'($signed(py)) * 256;
        z = 32'd0;
        if (px == 32'd0 && py == 32'd0) begin
            radius = 32'd0;
            angle = 16'd0;
            return;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + otc_pkg::atan_turns(5'(i));
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - otc_pkg::atan_turns(5'(i));
            end
        end
        mag = (x > 0) ? 64'(x) : 64'd0;
        prod = {32'd0, mag[31:0]} * {32'd0, otc_pkg::GainQ32};
        r = ({32'd0, mag[63:32]} * {32'd0, otc_pkg::GainQ32} + (prod >> 32) + 64'd128) >> 8;
        radius = (r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : r[31:0];
        zr = z + 32'h00008000;
        angle = zr[31:16];
    endtask

    // Fold one accepted sample into the run; queue a summary on the last one
    task automatic track_sample(input logic [31:0] px, input logic [31:0] py,
                                input logic last);
        logic [31:0] r;
        logic [15:0] a;
        logic [15:0] d;
        logic [63:0] f;
        logic [63:0] lo;
        logic [63:0] gr;
        logic [63:0] rl;
        t_summary    s;
        polar_of(px, py, r, a);
        if (!run_started) begin
            run_started = 1'b1;
            run_first = r;
            run_least = r;
            run_great = r;
            run_prev_angle = a;
            run_sweep = 48'd0;
        end else begin
            d = a - run_prev_angle;
            if (r < run_least) run_least = r;
            if (r > run_great) run_great = r;
            run_sweep = run_sweep + {{32{d[15]}}, d};
            run_prev_angle = a;
        end
        if (!last) return;
        f = 64'(run_first);
        lo = 64'(run_least);
        gr = 64'(run_great);
        rl = 64'(r);
        s.bounded = (5 * lo >= f) && (gr <= 3 * f);
        if (4 * lo < f && 2 * rl < f)
            s.cls = otc_pkg::CLS_PLUNGE;
        else if (2 * gr > 5 * f && 2 * rl > 3 * f)
            s.cls = otc_pkg::CLS_ESCAPE;
        else if (s.bounded)
            s.cls = (f != 0 && 4 * (gr - lo) <= f) ? otc_pkg::CLS_CIRCLE
                                                   : otc_pkg::CLS_BOUNDED;
        else
            s.cls = otc_pkg::CLS_UNCLEAR;
        s.r_first = run_first;
        s.r_last = r;
        s.r_least = run_least;
        s.r_great = run_great;
        s.drift = {1'b0, r} - {1'b0, run_first};
        s.revs = run_sweep;
        expected_summaries.insert(expected_summaries.size(), s);
        run_started = 1'b0;
    endtask

    task automatic push_sample(input logic [31:0] x, input logic [31:0] y,
                               input logic last);
        t_sample s;
        s.x = x;
        s.y = y;
        s.last = last;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    function automatic logic [31:0] to_pos(input real v);
        if (v > 2147483647.0) return 32'h7FFFFFFF;
        if (v < -2147483648.0) return 32'h80000000;
        return 32'($rtoi(v));
    endfunction

    function automatic real rnd_unit();
        return $urandom_range(0, 10000) / 10000.0;
    endfunction

    // Queue one run: 0 circular, 1 plunge, 2 escape, 3 bounded wander, 4 noise
    task automatic add_run(input int kind, input int len);
        real r0;
        real r;
        real th;
        real frac;
        r0 = real'($urandom_range(16, 32'h20000000));
        if ($urandom_range(0, 3) == 0) r0 = real'($urandom_range(1, 4096));
        th = rnd_unit() * 6.283185307179586;
        for (int i = 0; i < len; i++) begin
            frac = (len > 1) ? real'(i) / real'(len - 1) : 0.0;
            case (kind)
                0: r = r0 * (1.0 + 0.1 * (rnd_unit() - 0.5));
                1: r = r0 * (1.0 - 0.9 * frac);
                2: r = r0 * (1.0 + 3.0 * frac);
                3: r = r0 * (0.5 + 2.0 * rnd_unit());
                default: r = 0.0;
            endcase
            if (kind >= 4)
                push_sample($urandom, $urandom, i == len - 1);
            else
                push_sample(to_pos(r * $cos(th)), to_pos(r * $sin(th)), i == len - 1);
            th = th + (rnd_unit() * 2.0 - 0.5);
        end
    endtask

    task automatic add_random_runs(input int n_items, input int max_len);
        int added;
        int len;
        int k;
        added = 0;
        while (added < n_items) begin
            len = $urandom_range(1, max_len);
            k = $urandom_range(0, 9);
            add_run((k < 8) ? k % 4 : 4, len);
            added += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_summaries.size() != 0
               || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    // Input driver: advance to the next word on acceptance, idle at random
    always @(negedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready_seen) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s = pending_samples.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {s.y, s.x};
                s_axis_tlast <= s.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: track accepted samples, check result words
    always @(posedge i_clk) begin
        t_summary e;
        s_axis_tready_seen = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            s_axis_tready_seen = 1'b1;
            track_sample(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_axis_tdata);
            end else begin
                e = expected_summaries.pop_front();
                if (m_axis_tdata[2:0] !== e.cls || m_axis_tdata[34:3] !== e.r_first
                    || m_axis_tdata[66:35] !== e.r_last
                    || m_axis_tdata[98:67] !== e.r_least
                    || m_axis_tdata[130:99] !== e.r_great
                    || m_axis_tdata[163:131] !== e.drift
                    || m_axis_tdata[211:164] !== e.revs
                    || m_axis_tdata[212] !== e.bounded
                    || m_axis_tdata[215:213] !== 3'd0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp cls %0d first %h last %h least %h great %h",
                                 e.cls, e.r_first, e.r_last, e.r_least, e.r_great);
                        $display("  exp drift %h revs %h bnd %b; got word %h",
                                 e.drift, e.revs, e.bounded, m_axis_tdata);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 64'd0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        s_axis_tready_seen = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        mismatches = 0;
        cycles = 0;
        run_started = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Edge cases: origin-only run, single samples, half-turn step, extremes
        push_sample(32'd0, 32'd0, 1'b1);
        push_sample(32'd0, 32'd0, 1'b0);
        push_sample(32'd0, 32'd0, 1'b1);
        push_sample(32'h00010000, 32'd0, 1'b1);
        push_sample(32'h00010000, 32'd0, 1'b0);
        push_sample(32'hFFFF0000, 32'd0, 1'b1);
        push_sample(32'h00000001, 32'd0, 1'b0);
        push_sample(32'd0, 32'h00000001, 1'b0);
        push_sample(32'hFFFFFFFF, 32'd0, 1'b0);
        push_sample(32'd0, 32'hFFFFFFFF, 1'b1);
        push_sample(32'h80000000, 32'h80000000, 1'b0);
        push_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        push_sample(32'h80000000, 32'h7FFFFFFF, 1'b0);
        push_sample(32'h7FFFFFFF, 32'h80000000, 1'b1);
        push_sample(32'h00100000, 32'd0, 1'b0);
        push_sample(32'h00010000, 32'd0, 1'b1);
        push_sample(32'h00010000, 32'd0, 1'b0);
        push_sample(32'h00100000, 32'd0, 1'b1);
        push_sample(32'd0, 32'd0, 1'b0);
        push_sample(32'h00010000, 32'd0, 1'b1);
        wait_drained();

        // Random phases with different idling
        add_random_runs(300, 20);
        wait_drained();
        send_idle_pct = 79;
        add_random_runs(250, 20);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 79;
        add_random_runs(250, 12);
        wait_drained();
        send_idle_pct = 35;
        recv_stall_pct = 35;
        add_random_runs(250, 20);
        wait_drained();

        // Long receiver hold-off with short runs so the input backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_request = 1'b1;
        add_random_runs(200, 3);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_summaries.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/otc_pkg.sv
rtl/otc_ctrl.sv
rtl/otc_datapath.sv
rtl/orbit_trajectory_classifier.sv
dv/tb_top.sv
